@@ rtl/bee_pkg.sv @@
// Shared constants, types and command/status structs for the byte entropy estimator.
package bee_pkg;

  localparam int NUM_SYMBOLS    = 256;
  localparam int SYM_BITS       = 8;
  localparam int COUNT_BITS     = 20;
  localparam int IDX_BITS       = $clog2(NUM_SYMBOLS);
  localparam int DIST_BITS      = $clog2(NUM_SYMBOLS + 1);
  localparam int FRAC_BITS      = 16;
  localparam int FRAC_IDX_BITS  = $clog2(FRAC_BITS);
  localparam int LOG_INT_BITS   = $clog2(COUNT_BITS);
  localparam int LOG_BITS       = LOG_INT_BITS + FRAC_BITS;
  localparam int PROD_BITS      = COUNT_BITS + LOG_BITS;
  localparam int MANT_BITS      = 32;
  localparam int ENT_BITS       = 20;
  localparam int OUT_COUNT_BITS = 20;
  localparam int ENTROPY_MAX    = 524288;
  localparam int DIV_CNT_BITS   = $clog2(PROD_BITS + 1);

  // input operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_RD,
    ST_S_WR,
    ST_F_RD,
    ST_F_CHK,
    ST_F_LOG,
    ST_F_ACC,
    ST_F_NEXT,
    ST_N_CHK,
    ST_N_LOG,
    ST_N_DIV,
    ST_N_WAIT,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ,
    LG_UPD
  } log_phase_t;

  typedef struct packed {
    logic load_sym;
    logic set_drop;
    logic mem_rd;
    logic rd_bin;
    logic mem_wr;
    logic bin_clr;
    logic bin_inc;
    logic log_start;
    logic log_n;
    logic mul_load;
    logic acc;
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic saturated;
    logic bin_nz;
    logic bin_last;
    logic log_done;
    logic div_done;
    logic n_zero;
    logic out_busy;
  } dp_status_t;

endpackage

@@ rtl/bee_log2.sv @@
// Iterative fixed-point log2: shift normalize, then one squaring step per fraction bit.
module bee_log2 import bee_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] x,
  output logic                  done,
  output logic [LOG_BITS-1:0]   result
);

  log_phase_t                phase;
  logic [MANT_BITS-1:0]      m;
  logic [LOG_INT_BITS-1:0]   e;
  logic [FRAC_BITS-1:0]      frac;
  logic [FRAC_IDX_BITS-1:0]  bit_cnt;
  logic [2*MANT_BITS-1:0]    prod;
  logic [MANT_BITS:0]        sq;

  // square shifted back to Q2.31
  assign sq     = prod[2*MANT_BITS-1:MANT_BITS-1];
  assign result = {e, frac};

  // sequence normalize and squaring steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= LG_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        LG_IDLE: begin
          if (start) begin
            m     <= MANT_BITS'(x) << (MANT_BITS - COUNT_BITS);
            e     <= LOG_INT_BITS'(COUNT_BITS - 1);
            frac  <= '0;
            phase <= LG_NORM;
          end
        end
        LG_NORM: begin
          if (m[MANT_BITS-1]) begin
            bit_cnt <= FRAC_IDX_BITS'(FRAC_BITS - 1);
            phase   <= LG_SQ;
          end else begin
            m <= m << 1;
            e <= e - 1'b1;
          end
        end
        LG_SQ: begin
          prod  <= m * m;
          phase <= LG_UPD;
        end
        LG_UPD: begin
          if (sq[MANT_BITS]) begin
            frac[bit_cnt] <= 1'b1;
            m             <= sq[MANT_BITS:1];
          end else begin
            m <= sq[MANT_BITS-1:0];
          end
          if (bit_cnt == '0) begin
            done  <= 1'b1;
            phase <= LG_IDLE;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
            phase   <= LG_SQ;
          end
        end
        default: phase <= LG_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/bee_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module bee_divider import bee_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PROD_BITS-1:0]  dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [PROD_BITS-1:0]  quotient
);

  logic [COUNT_BITS:0]     rem;
  logic [COUNT_BITS:0]     rem_sh;
  logic [COUNT_BITS-1:0]   dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;

  assign rem_sh = {rem[COUNT_BITS-1:0], quotient[PROD_BITS-1]};

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        dvs      <= divisor;
        cnt      <= DIV_CNT_BITS'(PROD_BITS);
        busy     <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem      <= rem_sh - {1'b0, dvs};
          quotient <= {quotient[PROD_BITS-2:0], 1'b1};
        end else begin
          rem      <= rem_sh;
          quotient <= {quotient[PROD_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/bee_datapath.sv @@
// Histogram memory, counters, log2/multiply/accumulate path and result registers.
module bee_datapath import bee_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic [SYM_BITS-1:0]       symbol,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ENT_BITS-1:0]       entropy_q,
  output logic [OUT_COUNT_BITS-1:0] sample_count,
  output logic [DIST_BITS-1:0]      distinct_symbols,
  output logic                      overflow
);

  logic [COUNT_BITS-1:0]  mem [NUM_SYMBOLS];
  logic [COUNT_BITS-1:0]  mem_q;
  logic [NUM_SYMBOLS-1:0] bin_valid;
  logic                   rd_valid;
  logic [COUNT_BITS-1:0]  rd_count;
  logic [IDX_BITS-1:0]    sym_reg;
  logic [IDX_BITS-1:0]    bin_idx;
  logic [IDX_BITS-1:0]    rd_addr;
  logic [COUNT_BITS-1:0]  total;
  logic                   dropped;
  logic [DIST_BITS-1:0]   distinct;
  logic [COUNT_BITS-1:0]  c_reg;
  logic [PROD_BITS-1:0]   prod;
  logic [PROD_BITS-1:0]   sum;
  logic [PROD_BITS-1:0]   div_num;
  logic [LOG_BITS-1:0]    log_res;
  logic                   log_done;
  logic [PROD_BITS-1:0]   quo;
  logic                   div_done;
  logic                   clear;

  assign clear    = cmd.out_load;
  assign rd_count = rd_valid ? mem_q : '0;
  assign rd_addr  = cmd.rd_bin ? bin_idx : sym_reg;
  assign div_num  = (prod > sum) ? (prod - sum) : '0;

  // report status to the controller
  always_comb begin
    status.sym_ok    = ({1'b0, symbol} < (SYM_BITS + 1)'(NUM_SYMBOLS));
    status.saturated = &total;
    status.bin_nz    = (rd_count != '0);
    status.bin_last  = (bin_idx == IDX_BITS'(NUM_SYMBOLS - 1));
    status.log_done  = log_done;
    status.div_done  = div_done;
    status.n_zero    = (total == '0);
    status.out_busy  = out_valid && !out_ready;
  end

  // histogram storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[sym_reg] <= rd_count + 1'b1;
    if (cmd.mem_rd) begin
      mem_q    <= mem[rd_addr];
      rd_valid <= bin_valid[rd_addr];
    end
  end

  // valid bit per bin, cleared at once on finish
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bin_valid <= '0;
    end else if (cmd.mem_wr) begin
      bin_valid[sym_reg] <= 1'b1;
    end
  end

  // totals, flags and walk index
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      total    <= '0;
      dropped  <= 1'b0;
      distinct <= '0;
      sum      <= '0;
      bin_idx  <= '0;
    end else begin
      if (cmd.mem_wr)   total   <= total + 1'b1;
      if (cmd.set_drop) dropped <= 1'b1;
      if (cmd.bin_clr) begin
        bin_idx  <= '0;
        distinct <= '0;
        sum      <= '0;
      end
      if (cmd.bin_inc) bin_idx <= bin_idx + 1'b1;
      if (cmd.log_start && !cmd.log_n) distinct <= distinct + 1'b1;
      if (cmd.acc) sum <= sum + prod;
    end
  end

  // hold symbol and bin count, register products
  always_ff @(posedge clk) begin
    if (cmd.load_sym) sym_reg <= symbol[IDX_BITS-1:0];
    if (cmd.log_start && !cmd.log_n) c_reg <= rd_count;
    if (cmd.mul_load) prod <= (cmd.log_n ? total : c_reg) * log_res;
  end

  bee_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.log_start),
    .x      (cmd.log_n ? total : rd_count),
    .done   (log_done),
    .result (log_res)
  );

  bee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (total),
    .done     (div_done),
    .quotient (quo)
  );

  // result registers, valid drops on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (total == '0) begin
        entropy_q <= '0;
      end else if (quo > PROD_BITS'(ENTROPY_MAX)) begin
        entropy_q <= ENT_BITS'(ENTROPY_MAX);
      end else begin
        entropy_q <= quo[ENT_BITS-1:0];
      end
      sample_count     <= OUT_COUNT_BITS'(total);
      distinct_symbols <= distinct;
      overflow         <= dropped;
    end
  end

endmodule

@@ rtl/bee_ctrl.sv @@
// Controller state machine sequencing sample updates and the finish walk.
module bee_ctrl import bee_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_FINISH) state_next = ST_F_RD;
          else if (status.sym_ok && !status.saturated) state_next = ST_S_RD;
        end
      end
      ST_S_RD:   state_next = ST_S_WR;
      ST_S_WR:   state_next = ST_IDLE;
      ST_F_RD:   state_next = ST_F_CHK;
      ST_F_CHK:  state_next = status.bin_nz ? ST_F_LOG : ST_F_NEXT;
      ST_F_LOG:  if (status.log_done) state_next = ST_F_ACC;
      ST_F_ACC:  state_next = ST_F_NEXT;
      ST_F_NEXT: state_next = status.bin_last ? ST_N_CHK : ST_F_RD;
      ST_N_CHK:  state_next = status.n_zero ? ST_DONE : ST_N_LOG;
      ST_N_LOG:  if (status.log_done) state_next = ST_N_DIV;
      ST_N_DIV:  state_next = ST_N_WAIT;
      ST_N_WAIT: if (status.div_done) state_next = ST_DONE;
      ST_DONE:   if (!status.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (op == OP_FINISH) begin
            cmd.bin_clr = 1'b1;
          end else if (status.sym_ok) begin
            if (status.saturated) cmd.set_drop = 1'b1;
            else                  cmd.load_sym = 1'b1;
          end
        end
      end
      ST_S_RD: cmd.mem_rd = 1'b1;
      ST_S_WR: cmd.mem_wr = 1'b1;
      ST_F_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_bin = 1'b1;
      end
      ST_F_CHK:  if (status.bin_nz) cmd.log_start = 1'b1;
      ST_F_LOG:  if (status.log_done) cmd.mul_load = 1'b1;
      ST_F_ACC:  cmd.acc = 1'b1;
      ST_F_NEXT: if (!status.bin_last) cmd.bin_inc = 1'b1;
      ST_N_CHK: begin
        if (!status.n_zero) begin
          cmd.log_start = 1'b1;
          cmd.log_n     = 1'b1;
        end
      end
      ST_N_LOG: begin
        if (status.log_done) begin
          cmd.mul_load = 1'b1;
          cmd.log_n    = 1'b1;
        end
      end
      ST_N_DIV: cmd.div_start = 1'b1;
      ST_N_WAIT: ;
      ST_DONE:  if (!status.out_busy) cmd.out_load = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/byte_entropy_estimator.sv @@
// Top level of the byte entropy estimator: controller plus datapath.
//
//   channel | signals                                       | role
//   in      | in_valid, in_ready, op, symbol                 | sample or finish
//   out     | out_valid, out_ready, entropy_q, sample_count, | one result per
//           | distinct_symbols, overflow                     | finish
//
// A sample steps through accept, histogram read and write back; a dropped one ends at accept.
// A finish walks all 256 bins through read, check and next; each nonzero bin adds a log2
// (shift normalize, then one squaring step per fraction bit) and a multiply-accumulate.
// A log2 of the total and a serial restoring division follow.
// Reset clears the bin valid bits, the total and the overflow flag.
// A waiting result holds a following finish in its last state until transferred.
module byte_entropy_estimator import bee_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [SYM_BITS-1:0]       symbol,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ENT_BITS-1:0]       entropy_q,
  output logic [OUT_COUNT_BITS-1:0] sample_count,
  output logic [DIST_BITS-1:0]      distinct_symbols,
  output logic                      overflow
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  bee_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .symbol           (symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .entropy_q        (entropy_q),
    .sample_count     (sample_count),
    .distinct_symbols (distinct_symbols),
    .overflow         (overflow)
  );

endmodule

@@ rtl/bee_checker.sv @@
// Port-level checks for the byte entropy estimator, bound to the top level.
module bee_checker import bee_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      op,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ENT_BITS-1:0]       entropy_q,
  input logic [OUT_COUNT_BITS-1:0] sample_count,
  input logic [DIST_BITS-1:0]      distinct_symbols
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a sample transfer never raises a result
  a_sample_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_SAMPLE) |=> !$rose(out_valid))
    else $error("result raised by a sample");

  // entropy stays at or below 8.0
  a_ent_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entropy_q <= ENT_BITS'(ENTROPY_MAX))
    else $error("entropy above saturation");

  // one symbol or none carries no entropy
  a_single_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && distinct_symbols <= DIST_BITS'(1) |-> entropy_q == '0)
    else $error("nonzero entropy with at most one symbol");

  // no symbols seen means no samples counted
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && distinct_symbols == '0 |-> sample_count == '0)
    else $error("samples counted with an empty histogram");

endmodule

bind byte_entropy_estimator bee_checker u_bee_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .op               (op),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .entropy_q        (entropy_q),
  .sample_count     (sample_count),
  .distinct_symbols (distinct_symbols)
);
